### rtl/core/gpu_pkg.sv
package gpu_pkg;

    localparam int MAX_SAMPLES_DEFAULT   = 65536;
    localparam int MAX_BITS_DEFAULT      = 32;
    localparam int FRACTION_BITS_DEFAULT = 16;

    localparam int PROB_W  = 18;
    localparam int INDEX_W = 16;
    localparam int SC_W    = 17;
    localparam int AC_W    = 16;
    localparam int CFG_W   = 17;

    localparam logic [1:0] REG_LAYOUT  = 2'd0;
    localparam logic [1:0] REG_SAMPLES = 2'd1;
    localparam logic [1:0] REG_ALLELES = 2'd2;

    localparam logic [1:0] LAYOUT_V11 = 2'd1;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_SAMPLES = 3'd1;
    localparam logic [2:0] ERR_ALLELES = 3'd2;
    localparam logic [2:0] ERR_PLOIDY  = 3'd3;
    localparam logic [2:0] ERR_WIDTH   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PARSE,
        ST_EXTRACT,
        ST_DIV,
        ST_EMIT,
        ST_FINISH
    } state_t;

endpackage

### rtl/core/gpu_ram.sv
module gpu_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/core/genotype_probability_unpacker_top.sv
// Genotype probability block unpacker. Takes an uncompressed probability block one
// byte per transfer and returns one result per sample with three probabilities in
// signed fixed point (FRACTION_BITS fraction bits, 1.0 = 2^FRACTION_BITS). A header
// byte or a layout 1 byte is parsed and then finished; one that completes a sample or
// raises an error also passes the emit step. A layout 2 data byte is parsed, then each
// packed value it completes is extracted and divided by the single bit-serial restoring
// divider, which scales every value by 2^FRACTION_BITS/(2^nbit-1), and each sample it
// completes is emitted. A result waiting in the output register does not hold up the
// next byte until another result is ready. Missing flags live in a MAX_SAMPLES x 1 RAM
// without reset. Configuration writes are always taken and act at once.
module genotype_probability_unpacker_top #(
    parameter int MAX_SAMPLES   = gpu_pkg::MAX_SAMPLES_DEFAULT,
    parameter int MAX_BITS      = gpu_pkg::MAX_BITS_DEFAULT,
    parameter int FRACTION_BITS = gpu_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [gpu_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  data_byte,
    input  logic                        last_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [gpu_pkg::INDEX_W-1:0] sample_index,
    output logic signed [gpu_pkg::PROB_W-1:0] prob_first,
    output logic signed [gpu_pkg::PROB_W-1:0] prob_second,
    output logic signed [gpu_pkg::PROB_W-1:0] prob_third,
    output logic                        sample_missing,
    output logic [2:0]                  error_code,
    output logic                        last_result
);

    localparam int CNT_W  = ($clog2(MAX_SAMPLES + 1) > gpu_pkg::SC_W) ?
                            $clog2(MAX_SAMPLES + 1) : gpu_pkg::SC_W;
    localparam int RAM_AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int NB_W   = $clog2(MAX_BITS + 1);
    localparam int ACC_W  = MAX_BITS + 8;
    localparam int HELD_W = $clog2(MAX_BITS + 8);
    localparam int QUO_W  = FRACTION_BITS + 1;
    localparam int STEP_W = $clog2(FRACTION_BITS + 1);
    localparam int PW     = gpu_pkg::PROB_W;
    localparam logic [31:0] ONE32 = 32'(1) << FRACTION_BITS;
    localparam logic [PW-1:0] ONE = ONE32[PW-1:0];

    // configuration
    logic [1:0]               layout_reg;
    logic [gpu_pkg::SC_W-1:0] sc_reg;
    logic [gpu_pkg::AC_W-1:0] ac_reg;

    // control and block state
    gpu_pkg::state_t state_reg, state_next;
    logic              emit_loop_reg, emit_loop_next;
    logic [31:0]       pos_reg, pos_next;
    logic [31:0]       header_reg, header_next;
    logic [CNT_W-1:0]  nv_reg, nv_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              ploidy_ok_reg, ploidy_ok_next;
    logic [NB_W-1:0]   nbit_reg, nbit_next;
    logic [MAX_BITS-1:0] mask_reg, mask_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [HELD_W-1:0] held_reg, held_next;
    logic [PW-1:0]     pf_reg, pf_next;
    logic [PW-1:0]     ps_reg, ps_next;
    logic [1:0]        slot_reg, slot_next;
    logic [7:0]        low_reg, low_next;
    logic              drop_reg, drop_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;

    // payload
    logic [7:0]        byte_reg, byte_next;
    logic              last_reg, last_next;
    logic [MAX_BITS:0] rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [gpu_pkg::INDEX_W-1:0] res_idx_reg, res_idx_next;
    logic [PW-1:0]     res_p1_reg, res_p1_next;
    logic [PW-1:0]     res_p2_reg, res_p2_next;
    logic [PW-1:0]     res_p3_reg, res_p3_next;
    logic              res_miss_reg, res_miss_next;
    logic [2:0]        res_err_reg, res_err_next;
    logic              res_last_reg, res_last_next;
    logic [gpu_pkg::INDEX_W-1:0] o_idx_reg;
    logic [PW-1:0]     o_p1_reg, o_p2_reg, o_p3_reg;
    logic              o_miss_reg, o_last_reg;
    logic [2:0]        o_err_reg;
    logic              out_load;

    // missing flag RAM
    logic              ram_we;
    logic [31:0]       pos_m8;
    logic              ram_rd;

    gpu_ram #(
        .WIDTH(1),
        .DEPTH(MAX_SAMPLES)
    ) u_miss_ram (
        .clk    (clk),
        .wr_en  (ram_we),
        .wr_addr(pos_m8[RAM_AW-1:0]),
        .wr_data(byte_reg[7]),
        .rd_addr(cnt_reg[RAM_AW-1:0]),
        .rd_data(ram_rd)
    );

    assign pos_m8    = pos_reg - 32'd8;
    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == gpu_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_reg <= 2'd2;
            sc_reg     <= gpu_pkg::SC_W'(1);
            ac_reg     <= gpu_pkg::AC_W'(2);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == gpu_pkg::REG_LAYOUT)
            begin
                layout_reg <= cfg_data[1:0];
            end
            else if (cfg_index == gpu_pkg::REG_SAMPLES)
            begin
                sc_reg <= cfg_data[gpu_pkg::SC_W-1:0];
            end
            else if (cfg_index == gpu_pkg::REG_ALLELES)
            begin
                ac_reg <= cfg_data[gpu_pkg::AC_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gpu_pkg::ST_IDLE;
            emit_loop_reg <= 1'b0;
            pos_reg       <= '0;
            header_reg    <= '0;
            nv_reg        <= '0;
            cnt_reg       <= '0;
            ploidy_ok_reg <= 1'b1;
            nbit_reg      <= '0;
            mask_reg      <= '0;
            acc_reg       <= '0;
            held_reg      <= '0;
            pf_reg        <= '0;
            ps_reg        <= '0;
            slot_reg      <= '0;
            low_reg       <= '0;
            drop_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            emit_loop_reg <= emit_loop_next;
            pos_reg       <= pos_next;
            header_reg    <= header_next;
            nv_reg        <= nv_next;
            cnt_reg       <= cnt_next;
            ploidy_ok_reg <= ploidy_ok_next;
            nbit_reg      <= nbit_next;
            mask_reg      <= mask_next;
            acc_reg       <= acc_next;
            held_reg      <= held_next;
            pf_reg        <= pf_next;
            ps_reg        <= ps_next;
            slot_reg      <= slot_next;
            low_reg       <= low_next;
            drop_reg      <= drop_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        last_reg     <= last_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        res_idx_reg  <= res_idx_next;
        res_p1_reg   <= res_p1_next;
        res_p2_reg   <= res_p2_next;
        res_p3_reg   <= res_p3_next;
        res_miss_reg <= res_miss_next;
        res_err_reg  <= res_err_next;
        res_last_reg <= res_last_next;
        if (out_load)
        begin
            o_idx_reg  <= res_idx_reg;
            o_p1_reg   <= res_p1_reg;
            o_p2_reg   <= res_p2_reg;
            o_p3_reg   <= res_p3_reg;
            o_miss_reg <= res_miss_reg;
            o_err_reg  <= res_err_reg;
            o_last_reg <= res_last_reg;
        end
    end

    always_comb
    begin
        logic [33:0]       diff;
        logic [31:0]       hw;
        logic [PW-1:0]     v;
        logic [MAX_BITS:0] t;
        logic              ge;
        logic [31:0]       q32;
        logic [PW-1:0]     prob;
        logic [CNT_W-1:0]  cnt_inc;
        logic              fail;
        logic [2:0]        fail_code;

        state_next     = state_reg;
        emit_loop_next = emit_loop_reg;
        pos_next       = pos_reg;
        header_next    = header_reg;
        nv_next        = nv_reg;
        cnt_next       = cnt_reg;
        ploidy_ok_next = ploidy_ok_reg;
        nbit_next      = nbit_reg;
        mask_next      = mask_reg;
        acc_next       = acc_reg;
        held_next      = held_reg;
        pf_next        = pf_reg;
        ps_next        = ps_reg;
        slot_next      = slot_reg;
        low_next       = low_reg;
        drop_next      = drop_reg;
        step_next      = step_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        res_idx_next   = res_idx_reg;
        res_p1_next    = res_p1_reg;
        res_p2_next    = res_p2_reg;
        res_p3_next    = res_p3_reg;
        res_miss_next  = res_miss_reg;
        res_err_next   = res_err_reg;
        res_last_next  = res_last_reg;
        out_load       = 1'b0;
        ram_we         = 1'b0;

        diff      = {2'b00, pos_reg} - 34'd8 - 34'(nv_reg);
        hw        = header_reg | (32'(byte_reg) << {pos_reg[1:0], 3'b000});
        v         = {1'b0, byte_reg, low_reg, 1'b0};
        t         = (step_reg == '0) ? rem_reg : {rem_reg[MAX_BITS-1:0], 1'b0};
        ge        = (t >= {1'b0, mask_reg});
        q32       = 32'({quo_reg[QUO_W-2:0], ge});
        prob      = q32[PW-1:0];
        cnt_inc   = cnt_reg + CNT_W'(1);
        fail      = 1'b0;
        fail_code = gpu_pkg::ERR_NONE;

        unique case (state_reg)
            gpu_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next  = data_byte;
                    last_next  = last_byte;
                    state_next = gpu_pkg::ST_PARSE;
                end
            end

            gpu_pkg::ST_PARSE:
            begin
                state_next     = gpu_pkg::ST_FINISH;
                emit_loop_next = 1'b0;
                if (drop_reg)
                begin
                    state_next = gpu_pkg::ST_FINISH;
                end
                else if (layout_reg == gpu_pkg::LAYOUT_V11)
                begin
                    if (cnt_reg >= CNT_W'(sc_reg))
                    begin
                        drop_next = 1'b1;
                    end
                    else if (!pos_reg[0])
                    begin
                        low_next = byte_reg;
                    end
                    else if (slot_reg == 2'd0)
                    begin
                        pf_next   = v;
                        slot_next = 2'd1;
                    end
                    else if (slot_reg == 2'd1)
                    begin
                        ps_next   = v;
                        slot_next = 2'd2;
                    end
                    else
                    begin
                        res_idx_next  = cnt_reg[gpu_pkg::INDEX_W-1:0];
                        res_p1_next   = pf_reg;
                        res_p2_next   = ps_reg;
                        res_p3_next   = v;
                        res_miss_next = 1'b0;
                        res_err_next  = gpu_pkg::ERR_NONE;
                        res_last_next = (cnt_inc == CNT_W'(sc_reg));
                        slot_next     = 2'd0;
                        cnt_next      = cnt_inc;
                        if (cnt_inc >= CNT_W'(sc_reg))
                        begin
                            drop_next = 1'b1;
                        end
                        state_next = gpu_pkg::ST_EMIT;
                    end
                end
                else if (pos_reg < 32'd4)
                begin
                    header_next = hw;
                    if (pos_reg == 32'd3)
                    begin
                        if (hw != 32'(sc_reg) || hw > 32'(MAX_SAMPLES))
                        begin
                            fail      = 1'b1;
                            fail_code = gpu_pkg::ERR_SAMPLES;
                        end
                        else
                        begin
                            nv_next = hw[CNT_W-1:0];
                        end
                    end
                end
                else if (pos_reg == 32'd4)
                begin
                    header_next = 32'(byte_reg);
                end
                else if (pos_reg == 32'd5)
                begin
                    header_next = hw;
                    if (hw != 32'(ac_reg))
                    begin
                        fail      = 1'b1;
                        fail_code = gpu_pkg::ERR_ALLELES;
                    end
                    else if (hw != 32'd2)
                    begin
                        ploidy_ok_next = 1'b0;
                    end
                end
                else if (pos_reg == 32'd6 || pos_reg == 32'd7)
                begin
                    if (byte_reg != 8'd2)
                    begin
                        ploidy_ok_next = 1'b0;
                    end
                end
                else if (diff[33])
                begin
                    ram_we = 1'b1;
                end
                else if (diff == 34'd0)
                begin
                    if (byte_reg != 8'd0 || !ploidy_ok_reg)
                    begin
                        fail      = 1'b1;
                        fail_code = gpu_pkg::ERR_PLOIDY;
                    end
                end
                else if (diff == 34'd1)
                begin
                    if (byte_reg == 8'd0 || {1'b0, byte_reg} > 9'(MAX_BITS))
                    begin
                        fail      = 1'b1;
                        fail_code = gpu_pkg::ERR_WIDTH;
                    end
                    else
                    begin
                        nbit_next = byte_reg[NB_W-1:0];
                        mask_next = {MAX_BITS{1'b1}} >>
                                    (NB_W'(MAX_BITS) - byte_reg[NB_W-1:0]);
                    end
                end
                else if (cnt_reg >= nv_reg || nbit_reg == '0)
                begin
                    drop_next = 1'b1;
                end
                else
                begin
                    acc_next   = acc_reg | (ACC_W'(byte_reg) << held_reg);
                    held_next  = held_reg + HELD_W'(8);
                    state_next = gpu_pkg::ST_EXTRACT;
                end

                if (fail)
                begin
                    res_idx_next  = '0;
                    res_p1_next   = '0;
                    res_p2_next   = '0;
                    res_p3_next   = '0;
                    res_miss_next = 1'b0;
                    res_err_next  = fail_code;
                    res_last_next = 1'b1;
                    drop_next     = 1'b1;
                    state_next    = gpu_pkg::ST_EMIT;
                end
            end

            gpu_pkg::ST_EXTRACT:
            begin
                if (!drop_reg && held_reg >= HELD_W'(nbit_reg))
                begin
                    rem_next   = {1'b0, acc_reg[MAX_BITS-1:0] & mask_reg};
                    acc_next   = acc_reg >> nbit_reg;
                    held_next  = held_reg - HELD_W'(nbit_reg);
                    quo_next   = '0;
                    step_next  = '0;
                    state_next = gpu_pkg::ST_DIV;
                end
                else
                begin
                    state_next = gpu_pkg::ST_FINISH;
                end
            end

            gpu_pkg::ST_DIV:
            begin
                // restoring division, one quotient bit per cycle
                rem_next  = ge ? (t - {1'b0, mask_reg}) : t;
                quo_next  = {quo_reg[QUO_W-2:0], ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(FRACTION_BITS))
                begin
                    if (slot_reg == 2'd0)
                    begin
                        pf_next    = prob;
                        slot_next  = 2'd1;
                        state_next = gpu_pkg::ST_EXTRACT;
                    end
                    else
                    begin
                        res_idx_next  = cnt_reg[gpu_pkg::INDEX_W-1:0];
                        res_p1_next   = pf_reg;
                        res_p2_next   = prob;
                        res_p3_next   = ram_rd ? '0 : (ONE - pf_reg - prob);
                        res_miss_next = ram_rd;
                        res_err_next  = gpu_pkg::ERR_NONE;
                        res_last_next = (cnt_inc == nv_reg);
                        slot_next     = 2'd0;
                        cnt_next      = cnt_inc;
                        if (cnt_inc >= nv_reg)
                        begin
                            drop_next = 1'b1;
                            acc_next  = '0;
                            held_next = '0;
                        end
                        emit_loop_next = 1'b1;
                        state_next     = gpu_pkg::ST_EMIT;
                    end
                end
            end

            gpu_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = emit_loop_reg ? gpu_pkg::ST_EXTRACT : gpu_pkg::ST_FINISH;
                end
            end

            gpu_pkg::ST_FINISH:
            begin
                if (pos_reg != 32'hFFFF_FFFF)
                begin
                    pos_next = pos_reg + 32'd1;
                end
                if (last_reg)
                begin
                    pos_next       = '0;
                    header_next    = '0;
                    nv_next        = '0;
                    cnt_next       = '0;
                    ploidy_ok_next = 1'b1;
                    nbit_next      = '0;
                    acc_next       = '0;
                    held_next      = '0;
                    pf_next        = '0;
                    ps_next        = '0;
                    slot_next      = '0;
                    low_next       = '0;
                    drop_next      = 1'b0;
                end
                state_next = gpu_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = gpu_pkg::ST_IDLE;
            end
        endcase

        out_valid_next = out_load | (out_valid_reg & ~out_ready);
    end

    assign out_valid      = out_valid_reg;
    assign sample_index   = o_idx_reg;
    assign prob_first     = o_p1_reg;
    assign prob_second    = o_p2_reg;
    assign prob_third     = o_p3_reg;
    assign sample_missing = o_miss_reg;
    assign error_code     = o_err_reg;
    assign last_result    = o_last_reg;

`ifndef ASSERT_OFF
    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != gpu_pkg::ERR_NONE |-> last_result && !sample_missing)
        else $error("error result without last flag");

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= HELD_W'(MAX_BITS + 7))
        else $error("bit accumulator overfilled");

    a_one_byte_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("byte taken while another is in work");
`endif

endmodule
